// ----- design/bstack_pkg.sv -----
// ----------------------------------------------------------------------------
// bstack_pkg
// Shared constants, operation and status codes, and the command and status
// structs that join the stack controller to its datapath.
// ----------------------------------------------------------------------------
package bstack_pkg;

  // Stack geometry
  localparam int STACK_DEPTH = 8;
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  // Record fields
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 2;
  localparam int CODE_W   = 32;
  localparam int WEIGHT_W = 32;
  localparam int ENTRY_W  = CODE_W + WEIGHT_W;

  // Operation codes
  localparam logic [FUNC_W-1:0] OP_PUSH   = 2'd0;
  localparam logic [FUNC_W-1:0] OP_POP    = 2'd1;
  localparam logic [FUNC_W-1:0] OP_PEEK   = 2'd2;
  localparam logic [FUNC_W-1:0] OP_SEARCH = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic                req_load;   // capture the search key
    logic                wr_en;      // write the incoming record at the top
    logic                cnt_inc;
    logic                cnt_dec;
    logic                rd_en;
    logic                rd_next;    // 0: read the top entry, 1: read below the scan index
    logic                idx_top;    // load the scan index with the top address
    logic                idx_dec;
    logic                res_load;   // capture the pending result
    logic                res_data;   // 1: result record from memory, 0: zeros
    logic [STATUS_W-1:0] res_status;
    logic                out_load;   // move the pending result into the output register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic cnt_zero;
    logic cnt_full;
    logic hit;       // memory word matches the search key
    logic idx_zero;
  } dp_sts_t;

endpackage

// ----- design/bounded_stack_with_key_search.sv -----
// ----------------------------------------------------------------------------
// bounded_stack_with_key_search
// Fixed-depth LIFO stack of code/weight records with push, pop, peek and a
// top-down search by code. One result word per request.
//
//   channel  valid      stall      payload
//   -------  ---------  ---------  ------------------------------------------
//   input    in_valid   in_stall   in_func, in_code, in_weight
//   result   out_valid  out_stall  out_status, out_code, out_weight,
//                                  out_is_full, out_is_empty
//
// Push writes the record directly; pop and peek read the top entry first;
// a search compares one entry at a time, top down (single memory read port).
// One request is in work at a time; the next is taken while a finished
// result still waits in the output register.
// Reset (rst_n low, synchronous) empties the stack; memory contents are not
// cleared and are never read before being pushed.
// A stalled result holds the output register; the controller waits in its
// hand-off state until the register frees.
// ----------------------------------------------------------------------------
module bounded_stack_with_key_search (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [bstack_pkg::FUNC_W-1:0]         in_func,
  input  logic signed [bstack_pkg::CODE_W-1:0]  in_code,
  input  logic [bstack_pkg::WEIGHT_W-1:0]       in_weight,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [bstack_pkg::STATUS_W-1:0]       out_status,
  output logic signed [bstack_pkg::CODE_W-1:0]  out_code,
  output logic [bstack_pkg::WEIGHT_W-1:0]       out_weight,
  output logic                                  out_is_full,
  output logic                                  out_is_empty
);

  import bstack_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  bstack_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_func   (in_func),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  bstack_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_code      (in_code),
    .in_weight    (in_weight),
    .cmd          (cmd),
    .sts          (sts),
    .out_status   (out_status),
    .out_code     (out_code),
    .out_weight   (out_weight),
    .out_is_full  (out_is_full),
    .out_is_empty (out_is_empty)
  );

endmodule

// ----- design/bstack_ram.sv -----
// ----------------------------------------------------------------------------
// bstack_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bstack_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

// ----- design/bstack_dp.sv -----
// ----------------------------------------------------------------------------
// bstack_dp
// Stack datapath: record memory, entry count, scan index, search key,
// pending result and the output word register.
// ----------------------------------------------------------------------------
module bstack_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic signed [bstack_pkg::CODE_W-1:0]   in_code,
  input  logic [bstack_pkg::WEIGHT_W-1:0]        in_weight,
  input  bstack_pkg::dp_cmd_t                    cmd,
  output bstack_pkg::dp_sts_t                    sts,
  output logic [bstack_pkg::STATUS_W-1:0]        out_status,
  output logic signed [bstack_pkg::CODE_W-1:0]   out_code,
  output logic [bstack_pkg::WEIGHT_W-1:0]        out_weight,
  output logic                                   out_is_full,
  output logic                                   out_is_empty
);

  import bstack_pkg::*;

  logic [CNT_W-1:0]    cnt_r, cnt_nxt, cnt_m1;
  logic [ADDR_W-1:0]   idx_r, idx_nxt, top_addr, rd_addr;
  logic [CODE_W-1:0]   key_r;
  logic [ENTRY_W-1:0]  rd_data;
  logic [CODE_W-1:0]   rd_code;
  logic [WEIGHT_W-1:0] rd_weight;
  logic [STATUS_W-1:0] res_status_r;
  logic [CODE_W-1:0]   res_code_r;
  logic [WEIGHT_W-1:0] res_weight_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [CODE_W-1:0]   out_code_r;
  logic [WEIGHT_W-1:0] out_weight_r;
  logic                out_full_r, out_empty_r;

  // Address of the current top entry
  assign cnt_m1   = cnt_r - CNT_W'(1);
  assign top_addr = cnt_m1[ADDR_W-1:0];
  assign rd_addr  = cmd.rd_next ? (idx_r - ADDR_W'(1)) : top_addr;

  bstack_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (cnt_r[ADDR_W-1:0]),
    .wr_data ({in_code, in_weight}),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_code   = rd_data[ENTRY_W-1 -: CODE_W];
  assign rd_weight = rd_data[WEIGHT_W-1:0];

  // Entry count and scan index
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      cnt_nxt = cnt_m1;
    end
    idx_nxt = idx_r;
    if (cmd.idx_top) begin
      idx_nxt = top_addr;
    end else if (cmd.idx_dec) begin
      idx_nxt = idx_r - ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
  end

  // Capture the search key
  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      key_r <= in_code;
    end
  end

  // Hold the pending result
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_status_r <= cmd.res_status;
      res_code_r   <= cmd.res_data ? rd_code : '0;
      res_weight_r <= cmd.res_data ? rd_weight : '0;
    end
  end

  // Output word register, flags taken from the count after the operation
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_code_r   <= res_code_r;
      out_weight_r <= res_weight_r;
      out_full_r   <= sts.cnt_full;
      out_empty_r  <= sts.cnt_zero;
    end
  end

  assign out_status   = out_status_r;
  assign out_code     = out_code_r;
  assign out_weight   = out_weight_r;
  assign out_is_full  = out_full_r;
  assign out_is_empty = out_empty_r;

  // Status back to the controller
  always_comb begin
    sts          = '0;
    sts.cnt_zero = (cnt_r == '0);
    sts.cnt_full = (cnt_r == CNT_W'(STACK_DEPTH));
    sts.hit      = (rd_code == key_r);
    sts.idx_zero = (idx_r == '0);
  end

endmodule

// ----- design/bstack_ctrl.sv -----
// ----------------------------------------------------------------------------
// bstack_ctrl
// Stack controller: decodes each request, sequences the memory reads of a
// pop, peek or top-down search, and hands results to the output register.
// ----------------------------------------------------------------------------
module bstack_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bstack_pkg::FUNC_W-1:0] in_func,
  output logic                          out_valid,
  input  logic                          out_stall,
  output bstack_pkg::dp_cmd_t           cmd,
  input  bstack_pkg::dp_sts_t           sts
);

  import bstack_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [FUNC_W-1:0] func_r, func_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              accept;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  // Next state and datapath commands
  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.res_status = ST_OK;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          func_nxt     = in_func;
          cmd.req_load = 1'b1;
          case (in_func)
            OP_PUSH: begin
              cmd.res_load = 1'b1;
              if (sts.cnt_full) begin
                cmd.res_status = ST_FULL;
              end else begin
                cmd.wr_en   = 1'b1;
                cmd.cnt_inc = 1'b1;
              end
              state_nxt = S_FIN;
            end
            OP_POP, OP_PEEK: begin
              if (sts.cnt_zero) begin
                cmd.res_load   = 1'b1;
                cmd.res_status = ST_EMPTY;
                state_nxt      = S_FIN;
              end else begin
                cmd.rd_en = 1'b1;
                state_nxt = S_READ;
              end
            end
            default: begin
              if (sts.cnt_zero) begin
                cmd.res_load   = 1'b1;
                cmd.res_status = ST_EMPTY;
                state_nxt      = S_FIN;
              end else begin
                cmd.rd_en   = 1'b1;
                cmd.idx_top = 1'b1;
                state_nxt   = S_SCAN;
              end
            end
          endcase
        end
      end
      S_READ: begin
        cmd.res_load = 1'b1;
        cmd.res_data = 1'b1;
        cmd.cnt_dec  = (func_r == OP_POP);
        state_nxt    = S_FIN;
      end
      S_SCAN: begin
        // Compare the word read last cycle; advance downward on a miss
        if (sts.hit) begin
          cmd.res_load = 1'b1;
          cmd.res_data = 1'b1;
          state_nxt    = S_FIN;
        end else if (sts.idx_zero) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_MISSING;
          state_nxt      = S_FIN;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_next = 1'b1;
          cmd.idx_dec = 1'b1;
        end
      end
      S_FIN: begin
        // Hand off once the output register is free or being drained
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r <= func_nxt;
  end

endmodule

// ----- design/bstack_chk.sv -----
// ----------------------------------------------------------------------------
// bstack_chk
// Port-level checks on the stack's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module bstack_chk (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic [bstack_pkg::STATUS_W-1:0]       out_status,
  input logic signed [bstack_pkg::CODE_W-1:0]  out_code,
  input logic [bstack_pkg::WEIGHT_W-1:0]       out_weight,
  input logic                                  out_is_full,
  input logic                                  out_is_empty
);

  import bstack_pkg::*;

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_code))
    else $error("stalled result word changed");

  // A failed request carries no record
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> (out_code == '0) && (out_weight == '0))
    else $error("failed request returned a record");

  // Status codes agree with the fill flags
  a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |-> out_is_full && !out_is_empty)
    else $error("full status without full flag");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_EMPTY) |-> out_is_empty && !out_is_full)
    else $error("empty status without empty flag");

  // A search miss means entries were present to scan
  a_miss_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_MISSING) |-> !out_is_empty)
    else $error("search miss on an empty stack");

endmodule

bind bounded_stack_with_key_search bstack_chk u_bstack_chk (.*);
